// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the parser RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/core/omsrp_pkg.sv =====
// Package of the meter record parser: payload types, parse state, codes.
// Depends on nothing; used by every module of the parser.
`default_nettype none

package omsrp_pkg;

   localparam logic [3:0]  SKIP_COUNT_RESET = 4'd2;
   localparam int unsigned RSP_FIFO_DEPTH   = 4;

   localparam logic [7:0] END_MARK       = 8'h2F;
   localparam logic [7:0] VIF_DATE_TIME  = 8'h6D;
   localparam logic [6:0] VIF_VOLUME     = 7'h13;
   localparam logic [6:0] VIFE_BACKFLOW  = 7'h3C;
   localparam logic [7:0] VIF_EXTENDED   = 8'hFD;
   localparam logic [7:0] VIFE_STATUS    = 8'h17;
   localparam logic [7:0] VIF_DATE       = 8'h6C;
   localparam logic [3:0] DIF_VAR_LENGTH = 4'hD;

   localparam logic [2:0] KIND_DATE_TIME  = 3'd0;
   localparam logic [2:0] KIND_VOLUME     = 3'd1;
   localparam logic [2:0] KIND_BACKFLOW   = 3'd2;
   localparam logic [2:0] KIND_STATUS     = 3'd3;
   localparam logic [2:0] KIND_DATE       = 3'd4;
   localparam logic [2:0] KIND_UNKNOWN    = 3'd5;
   localparam logic [2:0] KIND_SUMMARY    = 3'd6;
   localparam logic [2:0] KIND_INCOMPLETE = 3'd7;

   typedef enum logic [2:0] {
      PH_SKIP,
      PH_DIF,
      PH_DIFE,
      PH_VIF,
      PH_VIFE,
      PH_LEN,
      PH_DATA,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [2:0]         record_kind;
      logic [3:0]         storage_number;
      logic [31:0]        raw_value;
      logic [7:0]         record_length;
      logic [7:0]         value_code;
      logic signed [31:0] total_volume;
      logic               volume_seen;
      logic [31:0]        meter_time;
      logic               time_seen;
      logic [7:0]         meter_status;
      logic               status_seen;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  skip_left;
      logic [3:0]  field_code;
      logic [3:0]  storage_held;
      logic [7:0]  vif_held;
      logic [7:0]  first_extension;
      logic        extension_present;
      logic [7:0]  bytes_left;
      logic [7:0]  length_held;
      logic [31:0] value_acc;
      logic [31:0] volume_reg;
      logic [31:0] time_reg;
      logic [7:0]  status_reg;
      logic [2:0]  seen_flags;
   } parse_state_type;

   function automatic logic [7:0] data_length(input logic [3:0] code);
      logic [7:0] len;
      case (code)
         4'h0: len = 8'd0;
         4'h1: len = 8'd1;
         4'h2: len = 8'd2;
         4'h3: len = 8'd3;
         4'h4: len = 8'd4;
         4'h5: len = 8'd4;
         4'h6: len = 8'd6;
         4'h7: len = 8'd8;
         4'h8: len = 8'd0;
         4'h9: len = 8'd1;
         4'hA: len = 8'd2;
         4'hB: len = 8'd3;
         4'hC: len = 8'd4;
         default: len = 8'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/omsrp_parse.sv =====
// Parse state of the meter record parser and the per-byte step logic.
// Depends on omsrp_pkg and assert_macros.svh; produces up to two results per byte.
`default_nettype none
`include "assert_macros.svh"

module omsrp_parse (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire omsrp_pkg::req_type item,
   input  wire logic              csr_wr_en,
   input  wire logic [3:0]        csr_wr_data,
   output omsrp_pkg::push_type    push
);

   localparam omsrp_pkg::parse_state_type STATE_RESET = '{
      phase:     omsrp_pkg::PH_SKIP,
      skip_left: omsrp_pkg::SKIP_COUNT_RESET,
      default:   '0
   };

   omsrp_pkg::parse_state_type state_ff;
   omsrp_pkg::parse_state_type state_in;
   logic [3:0]                 skip_count_ff;
   logic [3:0]                 skip_count_in;

   function automatic omsrp_pkg::parse_state_type take_dif(
      input omsrp_pkg::parse_state_type s_i,
      input logic [7:0]                 b
   );
      omsrp_pkg::parse_state_type s_o;
      s_o = s_i;
      if (b == omsrp_pkg::END_MARK) begin
         s_o.phase = omsrp_pkg::PH_DONE;
      end else begin
         s_o.field_code        = b[3:0];
         s_o.storage_held      = {3'b000, b[6]};
         s_o.extension_present = 1'b0;
         s_o.first_extension   = '0;
         s_o.phase             = b[7] ? omsrp_pkg::PH_DIFE : omsrp_pkg::PH_VIF;
      end
      return s_o;
   endfunction

   always_comb begin : step_logic
      omsrp_pkg::parse_state_type s;
      omsrp_pkg::rsp_type         rec;
      omsrp_pkg::rsp_type         summ;
      logic                       header_done;
      logic                       start;
      logic                       close;
      logic                       incomplete;
      logic                       back;
      logic [7:0]                 start_len;
      logic [7:0]                 idx;
      logic [7:0]                 b;
      logic [2:0]                 kind;

      s           = state_ff;
      rec         = '0;
      summ        = '0;
      header_done = 1'b0;
      start       = 1'b0;
      close       = 1'b0;
      incomplete  = 1'b0;
      back        = 1'b0;
      start_len   = '0;
      idx         = '0;
      b           = item.payload_byte;
      kind        = omsrp_pkg::KIND_UNKNOWN;
      skip_count_in = skip_count_ff;
      push        = '0;

      if (step) begin
         case (s.phase)
            omsrp_pkg::PH_SKIP: begin
               if (s.skip_left != 4'd0) begin
                  s.skip_left = s.skip_left - 4'd1;
                  if (s.skip_left == 4'd0) begin
                     s.phase = omsrp_pkg::PH_DIF;
                  end
               end else begin
                  s = take_dif(s, b);
               end
            end
            omsrp_pkg::PH_DIF: begin
               s = take_dif(s, b);
            end
            omsrp_pkg::PH_DIFE: begin
               s.storage_held = b[3:0];
               s.phase        = omsrp_pkg::PH_VIF;
            end
            omsrp_pkg::PH_VIF: begin
               s.vif_held = b;
               if (b[7]) begin
                  s.phase = omsrp_pkg::PH_VIFE;
               end else begin
                  header_done = 1'b1;
               end
            end
            omsrp_pkg::PH_VIFE: begin
               if (!s.extension_present) begin
                  s.first_extension   = b;
                  s.extension_present = 1'b1;
               end
               if (!b[7]) begin
                  header_done = 1'b1;
               end
            end
            omsrp_pkg::PH_LEN: begin
               start     = 1'b1;
               start_len = b;
            end
            omsrp_pkg::PH_DATA: begin
               idx = s.length_held - s.bytes_left;
               if (idx < 8'd4) begin
                  s.value_acc = s.value_acc | ({24'b0, b} << {idx[1:0], 3'b000});
               end
               s.bytes_left = s.bytes_left - 8'd1;
               if (s.bytes_left == 8'd0) begin
                  close   = 1'b1;
                  s.phase = omsrp_pkg::PH_DIF;
               end
            end
            default: begin
            end
         endcase

         if (header_done) begin
            if (s.field_code == omsrp_pkg::DIF_VAR_LENGTH) begin
               s.phase = omsrp_pkg::PH_LEN;
            end else begin
               start     = 1'b1;
               start_len = omsrp_pkg::data_length(s.field_code);
            end
         end

         // A final byte that leaves the header in the VIFE or LEN phase closes the header.
         if (item.is_final && !start &&
             (s.phase == omsrp_pkg::PH_VIFE || s.phase == omsrp_pkg::PH_LEN)) begin
            start     = 1'b1;
            start_len = (s.field_code == omsrp_pkg::DIF_VAR_LENGTH) ?
                        8'd0 : omsrp_pkg::data_length(s.field_code);
         end

         if (start) begin
            s.length_held = start_len;
            s.value_acc   = '0;
            if (start_len == 8'd0) begin
               close   = 1'b1;
               s.phase = omsrp_pkg::PH_DIF;
            end else begin
               s.bytes_left = start_len;
               s.phase      = omsrp_pkg::PH_DATA;
            end
         end

         // The header-closing start on the final byte may leave data pending.
         if (item.is_final && start && !close && header_done == 1'b0 &&
             s.phase == omsrp_pkg::PH_DATA && state_ff.phase != omsrp_pkg::PH_LEN) begin
            incomplete = 1'b1;
         end

         incomplete = incomplete || s.phase == omsrp_pkg::PH_DIFE ||
                      s.phase == omsrp_pkg::PH_VIF || s.phase == omsrp_pkg::PH_VIFE ||
                      s.phase == omsrp_pkg::PH_LEN || s.phase == omsrp_pkg::PH_DATA;

         if (close) begin
            if (s.vif_held == omsrp_pkg::VIF_DATE_TIME && s.length_held == 8'd4) begin
               kind          = omsrp_pkg::KIND_DATE_TIME;
               s.time_reg    = s.value_acc;
               s.seen_flags[1] = 1'b1;
            end else if (s.vif_held[6:0] == omsrp_pkg::VIF_VOLUME &&
                         s.length_held == 8'd4) begin
               back = s.extension_present &&
                      s.first_extension[6:0] == omsrp_pkg::VIFE_BACKFLOW;
               kind = back ? omsrp_pkg::KIND_BACKFLOW : omsrp_pkg::KIND_VOLUME;
               if (s.storage_held == 4'd0 && !back && !s.seen_flags[0]) begin
                  s.volume_reg    = s.value_acc;
                  s.seen_flags[0] = 1'b1;
               end
            end else if (s.vif_held == omsrp_pkg::VIF_EXTENDED && s.extension_present &&
                         s.first_extension == omsrp_pkg::VIFE_STATUS &&
                         s.length_held == 8'd1) begin
               kind            = omsrp_pkg::KIND_STATUS;
               s.status_reg    = s.value_acc[7:0];
               s.seen_flags[2] = 1'b1;
            end else if (s.vif_held == omsrp_pkg::VIF_DATE && s.length_held == 8'd2) begin
               kind = omsrp_pkg::KIND_DATE;
            end
            rec.record_kind    = kind;
            rec.storage_number = s.storage_held;
            rec.raw_value      = s.value_acc;
            rec.record_length  = s.length_held;
            rec.value_code     = s.vif_held;
            rec.total_volume   = $signed(s.volume_reg);
            rec.volume_seen    = s.seen_flags[0];
            rec.meter_time     = s.time_reg;
            rec.time_seen      = s.seen_flags[1];
            rec.meter_status   = s.status_reg;
            rec.status_seen    = s.seen_flags[2];
         end

         summ.record_kind  = incomplete ? omsrp_pkg::KIND_INCOMPLETE : omsrp_pkg::KIND_SUMMARY;
         summ.total_volume = $signed(s.volume_reg);
         summ.volume_seen  = s.seen_flags[0];
         summ.meter_time   = s.time_reg;
         summ.time_seen    = s.seen_flags[1];
         summ.meter_status = s.status_reg;
         summ.status_seen  = s.seen_flags[2];

         push.count  = {1'b0, close} + {1'b0, item.is_final};
         push.first  = close ? rec : summ;
         push.second = summ;

         if (item.is_final) begin
            s           = '0;
            s.phase     = omsrp_pkg::PH_SKIP;
            s.skip_left = skip_count_ff;
         end
      end

      if (csr_wr_en) begin
         skip_count_in = csr_wr_data;
         s.skip_left   = csr_wr_data;
      end

      state_in = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_RESET;
         skip_count_ff <= omsrp_pkg::SKIP_COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         skip_count_ff <= skip_count_in;
      end
   end

   `ASSERT_NEXT(a_final_restarts, clock, reset, step && item.is_final && !csr_wr_en, state_ff.phase == omsrp_pkg::PH_SKIP && state_ff.seen_flags == 3'b000)
   `ASSERT_NEXT(a_end_mark_holds, clock, reset, step && !item.is_final && state_ff.phase == omsrp_pkg::PH_DONE, state_ff.phase == omsrp_pkg::PH_DONE)

endmodule

`default_nettype wire

// ===== rtl/core/omsrp_rsp_fifo.sv =====
// Result queue of the meter record parser: takes up to two results a cycle.
// Depends on omsrp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module omsrp_rsp_fifo #(
   parameter int unsigned DEPTH = omsrp_pkg::RSP_FIFO_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire omsrp_pkg::push_type push,
   output logic                    room,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output omsrp_pkg::rsp_type      rsp_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   omsrp_pkg::rsp_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_next;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign pop         = rsp_valid && rsp_ready;
   assign rsp_valid   = count_ff != '0;
   assign rsp_data    = mem_ff[rd_ptr_ff];
   assign room        = count_ff <= CNT_W'(DEPTH - 2);
   assign wr_ptr_next = ptr_inc(wr_ptr_ff);

   always_comb begin
      case (push.count)
         2'd1:    wr_ptr_in = wr_ptr_next;
         2'd2:    wr_ptr_in = ptr_inc(wr_ptr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_IMPLIES(a_push_fits, clock, reset, push.count != 2'd0, room)
   `ASSERT_NEXT(a_idle_count_holds, clock, reset, push.count == 2'd0 && !pop, $stable(count_ff))

endmodule

`default_nettype wire

// ===== rtl/core/oms_meter_record_parser.sv =====
// Top level of the meter record parser: input register, parse step, result queue.
// Depends on omsrp_pkg, omsrp_parse, omsrp_rsp_fifo and assert_macros.svh.
//
//   Channel  Ports                             Carries
//   req      req_valid, req_ready, req_data    one payload byte and its last-byte flag
//   rsp      rsp_valid, rsp_ready, rsp_data    one record or end-of-payload result
//   csr      csr_wr_en, csr_wr_data            skip count, written without wait
//
// One byte is accepted per cycle while req_ready is high; it is registered, then parsed.
// A byte yields zero, one or two results, which enter a queue of RSP_DEPTH entries.
// The parse step advances only while the queue has room for two results, so req_ready
// drops when rsp_ready has been low long enough to fill the queue.
// Reset is synchronous and clears the parse state; the skip count returns to 2.
`default_nettype none
`include "assert_macros.svh"

module oms_meter_record_parser #(
   parameter int unsigned RSP_DEPTH = omsrp_pkg::RSP_FIFO_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire omsrp_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output omsrp_pkg::rsp_type      rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [3:0]         csr_wr_data
);

   logic               in_valid_ff;
   logic               in_valid_in;
   omsrp_pkg::req_type in_data_ff;
   logic               advance;
   logic               room;
   logic               req_accept;
   omsrp_pkg::push_type push;

   assign advance    = in_valid_ff && room;
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
   end

   omsrp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item        (in_data_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push)
   );

   omsrp_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `ASSERT_NEXT(a_held_byte_stays, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_data_ff))

endmodule

`default_nettype wire
